[rtl/core/rfc_pkg.sv]
// rfc_pkg: shared widths, codes, result types and byte helpers for the reply frame checker
// no dependencies; used by the interfaces and every module under rtl/core
package rfc_pkg;

    localparam int BYTE_W      = 8;
    localparam int POS_W       = 4;
    localparam int CODE_W      = 3;
    localparam int BLOCK_W     = 12;
    localparam int FRONTEND_W  = 4;
    localparam int COMMAND_W   = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int TAIL_DEPTH  = 3;

    // default depth of the result queue
    localparam int QUEUE_DEPTH_DEF = 4;

    // frame byte counts: bytes seen before payload starts leaving the tail line, short limit, xor start
    localparam logic [POS_W-1:0] FULL_COUNT  = 4'd9;
    localparam logic [POS_W-1:0] SHORT_LIMIT = 4'd8;
    localparam logic [POS_W-1:0] TAIL_START  = 4'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BLOCK    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FRONTEND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_COMMAND  = 2'd2;

    // frame byte positions
    localparam logic [POS_W-1:0] POS_START   = 4'd0;
    localparam logic [POS_W-1:0] POS_BLK_HI  = 4'd1;
    localparam logic [POS_W-1:0] POS_BLK_MID = 4'd2;
    localparam logic [POS_W-1:0] POS_BLK_LO  = 4'd3;
    localparam logic [POS_W-1:0] POS_FE      = 4'd4;
    localparam logic [POS_W-1:0] POS_CMD     = 4'd5;

    // control characters
    localparam logic [BYTE_W-1:0] CH_STX = 8'h02;
    localparam logic [BYTE_W-1:0] CH_ETX = 8'h03;
    localparam logic [BYTE_W-1:0] CH_ACK = 8'h06;
    localparam logic [BYTE_W-1:0] CH_NAK = 8'h15;
    localparam logic [BYTE_W-1:0] CH_TIM = 8'h18;
    localparam logic [BYTE_W-1:0] CH_ERR = 8'h1a;
    localparam logic [BYTE_W-1:0] CH_ESC = 8'h1b;

    // start byte classes
    localparam logic [CODE_W-1:0] START_STX   = 3'd0;
    localparam logic [CODE_W-1:0] START_ACK   = 3'd1;
    localparam logic [CODE_W-1:0] START_NAK   = 3'd2;
    localparam logic [CODE_W-1:0] START_TIM   = 3'd3;
    localparam logic [CODE_W-1:0] START_ERR   = 3'd4;
    localparam logic [CODE_W-1:0] START_ESC   = 3'd5;
    localparam logic [CODE_W-1:0] START_OTHER = 3'd6;

    // frame outcomes
    localparam logic [CODE_W-1:0] OUT_ACCEPTED = 3'd0;
    localparam logic [CODE_W-1:0] OUT_CHECKSUM = 3'd1;
    localparam logic [CODE_W-1:0] OUT_ECHO     = 3'd2;
    localparam logic [CODE_W-1:0] OUT_TIMEOUT  = 3'd3;
    localparam logic [CODE_W-1:0] OUT_OTHER    = 3'd4;
    localparam logic [CODE_W-1:0] OUT_SHORT    = 3'd5;

    typedef struct packed {
        logic [BLOCK_W-1:0]    block;
        logic [FRONTEND_W-1:0] frontend;
        logic [COMMAND_W-1:0]  command;
    } t_cfg;

    typedef struct packed {
        logic              is_status;
        logic [BYTE_W-1:0] payload_byte;
        logic [CODE_W-1:0] start_code;
        logic [CODE_W-1:0] outcome;
        logic              checksum_ok;
        logic              end_marker_ok;
        logic              last;
    } t_result;

    // what one accepted beat produces
    typedef struct packed {
        logic    push_pay;
        logic    push_stat;
        t_result pay;
        t_result stat;
    } t_eval;

    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
        logic [BYTE_W-1:0] res;
        if (nib < 4'd10) begin
            res = 8'h30 + {4'd0, nib};
        end else begin
            res = 8'h37 + {4'd0, nib};
        end
        return res;
    endfunction

    // {is_hex, value}
    function automatic logic [4:0] hex_decode(input logic [BYTE_W-1:0] c);
        logic [4:0] res;
        if (c >= 8'h30 && c <= 8'h39) begin
            res = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            res = {1'b1, c[3:0] + 4'd9};
        end else begin
            res = 5'd0;
        end
        return res;
    endfunction

    function automatic logic [CODE_W-1:0] classify(input logic [BYTE_W-1:0] b);
        logic [CODE_W-1:0] res;
        unique case (b)
            CH_STX:  res = START_STX;
            CH_ACK:  res = START_ACK;
            CH_NAK:  res = START_NAK;
            CH_TIM:  res = START_TIM;
            CH_ERR:  res = START_ERR;
            CH_ESC:  res = START_ESC;
            default: res = START_OTHER;
        endcase
        return res;
    endfunction

endpackage

[rtl/core/rfc_in_if.sv]
// rfc_in_if: valid/ready channel carrying received frame bytes
// depends on rfc_pkg for the byte width
interface rfc_in_if;
    import rfc_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    logic              end_of_frame;

    modport source (output valid, output rx_byte, output end_of_frame, input ready);
    modport sink   (input valid, input rx_byte, input end_of_frame, output ready);
endinterface

[rtl/core/rfc_out_if.sv]
// rfc_out_if: valid/ready channel carrying payload and status results
// depends on rfc_pkg for field widths
interface rfc_out_if;
    import rfc_pkg::*;

    logic              valid;
    logic              ready;
    logic              is_status;
    logic [BYTE_W-1:0] payload_byte;
    logic [CODE_W-1:0] start_code;
    logic [CODE_W-1:0] outcome;
    logic              checksum_ok;
    logic              end_marker_ok;
    logic              last;

    modport source (output valid, output is_status, output payload_byte, output start_code,
                    output outcome, output checksum_ok, output end_marker_ok, output last,
                    input ready);
    modport sink   (input valid, input is_status, input payload_byte, input start_code,
                    input outcome, input checksum_ok, input end_marker_ok, input last,
                    output ready);
endinterface

[rtl/core/reply_frame_checker_core.sv]
// reply_frame_checker_core: top level of the reply frame checker
// depends on rfc_pkg, rfc_in_if, rfc_out_if, rfc_frame_eval and rfc_result_queue
//
// Usage:
//   i_in carries one frame byte per beat, end_of_frame set on the final byte.
//   o_out carries the results: payload bytes (positions 6..N-4) with is_status 0,
//   then one status beat with last 1 holding start class, outcome, checksum
//   and end marker flags. Frames under nine bytes give only a status beat
//   with the short frame outcome.
//   The config port (i_cfg_we, i_cfg_idx, i_cfg_data) loads the expected
//   block, front end and command; write it between frames.
// Timing:
//   A byte is evaluated in the cycle it is accepted and its results are in the
//   result queue the next cycle.
//   One byte per cycle is sustained while o_out takes every result; the final
//   byte of a long frame pushes two results, which the queue absorbs. ready
//   drops when the queue has fewer than two free slots. Stalls on o_out leave
//   results queued until header bytes, which push nothing, let them drain; a
//   final byte taken with two results already queued drops ready.
// Reset:
//   Synchronous active-low reset empties the queue, clears the frame state
//   and zeroes the config registers; ready stays low while reset is held.
module reply_frame_checker_core #(
    parameter int QUEUE_DEPTH = rfc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rfc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rfc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    rfc_in_if.sink                        i_in,
    rfc_out_if.source                     o_out
);
    import rfc_pkg::*;

    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

    t_cfg             r_cfg;
    t_eval            eval;
    t_result          head;
    logic [LVL_W-1:0] level;
    logic             take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDX_BLOCK:    r_cfg.block    <= i_cfg_data[BLOCK_W-1:0];
                CFG_IDX_FRONTEND: r_cfg.frontend <= i_cfg_data[FRONTEND_W-1:0];
                CFG_IDX_COMMAND:  r_cfg.command  <= i_cfg_data[COMMAND_W-1:0];
                default: ;
            endcase
        end
    end

    // room for two results: a long frame's final byte pushes payload and status
    assign i_in.ready = i_rst_n && (level <= LVL_W'(QUEUE_DEPTH - 2));
    assign take       = i_in.valid && i_in.ready;

    rfc_frame_eval u_eval (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_rx_byte (i_in.rx_byte),
        .i_eof     (i_in.end_of_frame),
        .i_cfg     (r_cfg),
        .o_eval    (eval)
    );

    rfc_result_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_eval  (eval),
        .i_pop   (o_out.ready),
        .o_valid (o_out.valid),
        .o_head  (head),
        .o_level (level)
    );

    assign o_out.is_status     = head.is_status;
    assign o_out.payload_byte  = head.payload_byte;
    assign o_out.start_code    = head.start_code;
    assign o_out.outcome       = head.outcome;
    assign o_out.checksum_ok   = head.checksum_ok;
    assign o_out.end_marker_ok = head.end_marker_ok;
    assign o_out.last          = head.last;

    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        level <= LVL_W'(QUEUE_DEPTH))
        else $error("result queue overfilled");

    a_out_empty_after_reset : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result beat present right after reset");

    a_last_is_status : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.last == o_out.is_status))
        else $error("last flag and status flag disagree");

    a_short_flags : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.is_status && o_out.outcome == OUT_SHORT)
        |-> (!o_out.checksum_ok && !o_out.end_marker_ok))
        else $error("short frame status carries check flags");

    a_eof_push : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_in.end_of_frame) |=> (level != '0))
        else $error("final byte left no status in the queue");

endmodule

[rtl/core/rfc_frame_eval.sv]
// rfc_frame_eval: per-frame state (position, xor, tail line, start class, echo flag)
// and the results one accepted byte produces; depends on rfc_pkg
module rfc_frame_eval (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_take,
    input  logic [rfc_pkg::BYTE_W-1:0] i_rx_byte,
    input  logic                      i_eof,
    input  rfc_pkg::t_cfg             i_cfg,
    output rfc_pkg::t_eval            o_eval
);
    import rfc_pkg::*;

    logic [POS_W-1:0]  r_pos,   n_pos;
    logic [BYTE_W-1:0] r_xor,   n_xor;
    logic [BYTE_W-1:0] r_tail [TAIL_DEPTH];
    logic [BYTE_W-1:0] n_tail [TAIL_DEPTH];
    logic [CODE_W-1:0] r_start, n_start;
    logic              r_echo,  n_echo;

    logic [BYTE_W-1:0] expect_byte;
    logic              check;
    logic [4:0]        hi_dec;
    logic [4:0]        lo_dec;
    logic              cks_ok;
    logic              etx_ok;
    logic [CODE_W-1:0] outcome;

    always_comb begin
        expect_byte = '0;
        check       = 1'b1;
        unique case (r_pos)
            POS_BLK_HI:  expect_byte = hex_char(i_cfg.block[11:8]);
            POS_BLK_MID: expect_byte = hex_char(i_cfg.block[7:4]);
            POS_BLK_LO:  expect_byte = hex_char(i_cfg.block[3:0]);
            POS_FE:      expect_byte = hex_char(i_cfg.frontend);
            POS_CMD:     expect_byte = i_cfg.command;
            default:     check = 1'b0;
        endcase

        n_start = (r_pos == POS_START) ? classify(i_rx_byte) : r_start;
        n_echo  = r_echo | (check && (i_rx_byte != expect_byte));
        n_xor   = (r_pos >= TAIL_START) ? (r_xor ^ r_tail[2]) : r_xor;
        n_pos   = (r_pos < FULL_COUNT) ? r_pos + 4'd1 : r_pos;
        n_tail[0] = i_rx_byte;
        n_tail[1] = r_tail[0];
        n_tail[2] = r_tail[1];

        // checksum chars are the newest two bytes, end marker the one before
        hi_dec = hex_decode(n_tail[1]);
        lo_dec = hex_decode(n_tail[0]);
        cks_ok = hi_dec[4] && lo_dec[4] && ({hi_dec[3:0], lo_dec[3:0]} == n_xor);
        etx_ok = (n_tail[2] == CH_ETX);

        if (!cks_ok) begin
            outcome = OUT_CHECKSUM;
        end else if (n_start == START_ACK || n_start == START_ESC) begin
            outcome = n_echo ? OUT_ECHO : OUT_ACCEPTED;
        end else if (n_start == START_TIM) begin
            outcome = OUT_TIMEOUT;
        end else begin
            outcome = OUT_OTHER;
        end

        o_eval.push_pay  = i_take && (r_pos >= FULL_COUNT);
        o_eval.push_stat = i_take && i_eof;

        o_eval.pay              = '0;
        o_eval.pay.payload_byte = r_tail[2];

        o_eval.stat            = '0;
        o_eval.stat.is_status  = 1'b1;
        o_eval.stat.last       = 1'b1;
        o_eval.stat.start_code = n_start;
        if (r_pos < SHORT_LIMIT) begin
            o_eval.stat.outcome = OUT_SHORT;
        end else begin
            o_eval.stat.outcome       = outcome;
            o_eval.stat.checksum_ok   = cks_ok;
            o_eval.stat.end_marker_ok = etx_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_xor   <= '0;
            r_start <= '0;
            r_echo  <= 1'b0;
            for (int k = 0; k < TAIL_DEPTH; k++) begin
                r_tail[k] <= '0;
            end
        end else if (i_take) begin
            if (i_eof) begin
                // frame done, back to a clean slate
                r_pos   <= '0;
                r_xor   <= '0;
                r_start <= '0;
                r_echo  <= 1'b0;
                for (int k = 0; k < TAIL_DEPTH; k++) begin
                    r_tail[k] <= '0;
                end
            end else begin
                r_pos   <= n_pos;
                r_xor   <= n_xor;
                r_start <= n_start;
                r_echo  <= n_echo;
                for (int k = 0; k < TAIL_DEPTH; k++) begin
                    r_tail[k] <= n_tail[k];
                end
            end
        end
    end

endmodule

[rtl/core/rfc_result_queue.sv]
// rfc_result_queue: small result queue taking up to two results per cycle, one out
// depends on rfc_pkg for the result type
module rfc_result_queue #(
    parameter int QUEUE_DEPTH = rfc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rfc_pkg::t_eval                   i_eval,
    input  logic                             i_pop,
    output logic                             o_valid,
    output rfc_pkg::t_result                 o_head,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] o_level
);
    import rfc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    t_result          r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [LVL_W-1:0] r_level, n_level;
    logic [PTR_W-1:0] wptr_1;
    logic [PTR_W-1:0] wptr_2;
    logic [PTR_W-1:0] stat_ptr;
    logic             pop;

    assign pop      = i_pop && (r_level != '0);
    assign wptr_1   = (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
    assign wptr_2   = (wptr_1 == PTR_LAST) ? '0 : wptr_1 + 1'b1;
    // status lands behind the payload byte when both come from one beat
    assign stat_ptr = i_eval.push_pay ? wptr_1 : r_wptr;

    always_comb begin
        n_rptr = pop ? ((r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1) : r_rptr;
        unique case ({i_eval.push_pay, i_eval.push_stat}) inside
            2'b11:        n_wptr = wptr_2;
            2'b10, 2'b01: n_wptr = wptr_1;
            default:      n_wptr = r_wptr;
        endcase
        n_level = r_level + LVL_W'(i_eval.push_pay) + LVL_W'(i_eval.push_stat)
                  - LVL_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_eval.push_pay) begin
            r_mem[r_wptr] <= i_eval.pay;
        end
        if (i_eval.push_stat) begin
            r_mem[stat_ptr] <= i_eval.stat;
        end
    end

    assign o_valid = (r_level != '0);
    assign o_head  = r_mem[r_rptr];
    assign o_level = r_level;

endmodule
